/* design/bba_pkg.sv */
// Shared types, constants and helper functions of the buddy block allocator.
package bba_pkg;

    localparam int POOL_CHUNKS  = 8;
    localparam int HEADER_BYTES = 16;
    localparam int POOL_LIMIT   = (POOL_CHUNKS < 8) ? POOL_CHUNKS : 8;
    localparam int FREE_ROWS    = 65;
    localparam int ORDER_ROWS   = 128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_PICK,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_BOM_RD,
        ST_BOM_WR,
        ST_FREE_CHK,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_SETFREE_RD,
        ST_SETFREE_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        STAT_OK          = 2'd0,
        STAT_TOO_LARGE   = 2'd1,
        STAT_NO_MEM      = 2'd2,
        STAT_DOUBLE_FREE = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic [6:0] row;
        logic [4:0] bitn;
    } t_floc;

    typedef struct packed {
        logic        wr_en;
        logic [6:0]  wr_row;
        logic [31:0] wr_data;
        logic [6:0]  rd_row;
    } t_mem_req;

    function automatic logic [6:0] row_base(input logic [2:0] j);
        logic [6:0] b;
        unique case (j)
            3'd0: b = 7'd0;
            3'd1: b = 7'd32;
            3'd2: b = 7'd48;
            3'd3: b = 7'd56;
            3'd4: b = 7'd60;
            3'd5: b = 7'd62;
            3'd6: b = 7'd63;
            3'd7: b = 7'd64;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] row_mask(input logic [2:0] j);
        logic [31:0] m;
        unique case (j)
            3'd0: m = 32'hFFFF_FFFF;
            3'd1: m = 32'h0000_FFFF;
            3'd2: m = 32'h0000_00FF;
            3'd3: m = 32'h0000_000F;
            3'd4: m = 32'h0000_0003;
            3'd5: m = 32'h0000_0001;
            3'd6: m = 32'h0000_0001;
            3'd7: m = 32'h0000_0001;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] lowest_set(input logic [31:0] v);
        logic [4:0] r;
        r = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) r = 5'(i);
        end
        return r;
    endfunction

    function automatic t_floc free_loc(input logic [2:0] j, input logic [13:0] a);
        t_floc      l;
        logic [9:0] idx;
        idx    = 10'(a[13:4] >> j);
        l.row  = row_base(j) + 7'(idx[9:5]);
        l.bitn = idx[4:0];
        return l;
    endfunction

endpackage

/* design/buddy_block_allocator.sv */
// Buddy block allocator top level: request sequencer, block locator and result register.
// A request rejected on acceptance goes straight to ST_DONE. An allocate scans one order per
// cycle, claims a block, then passes SPLIT_RD and SPLIT_WR per split and BOM_RD and BOM_WR
// on the order store; a free passes MERGE_RD and MERGE_CHK per merge step. The next request
// is taken as its result is presented; ST_DONE waits while an older result lacks i_ready.
// Reset clears control state and store valid flags; the block is ready once reset is released.
module buddy_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [15:0] i_request_bytes,
    input  logic [13:0] i_block_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [13:0] o_granted_address,
    output logic [1:0]  o_status
);

    bba_pkg::t_state  r_state, n_state;
    logic [2:0]       r_j, n_j;
    logic [2:0]       r_k, n_k;
    logic [13:0]      r_addr, n_addr;
    logic [6:0]       r_row, n_row;
    logic [3:0]       r_chunks, n_chunks;
    logic [13:0]      r_res_addr, n_res_addr;
    bba_pkg::t_status r_res_status, n_res_status;
    logic             r_ovalid, n_ovalid;
    logic [13:0]      r_ogrant, n_ogrant;
    logic [1:0]       r_ostatus, n_ostatus;

    bba_pkg::t_mem_req fm_req, om_req;
    logic [31:0]       fm_rd, om_rd;
    logic              fm_found;
    logic [6:0]        fm_found_row;

    logic [2:0]       jj;
    logic [13:0]      sz, loc_addr, blk, new_addr;
    bba_pkg::t_floc   loc;
    logic [16:0]      need;
    logic [2:0]       kreq;
    logic [4:0]       pick_bit;
    logic [4:0]       rel_row;
    logic [3:0]       code;
    logic [31:0]      nib_mask;

    bba_free_map u_free_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (fm_req),
        .i_order     (r_j),
        .o_rd_data   (fm_rd),
        .o_found     (fm_found),
        .o_found_row (fm_found_row)
    );

    bba_order_map u_order_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (om_req),
        .o_rd_data (om_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bba_pkg::ST_IDLE;
            r_chunks <= 4'd0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_chunks <= n_chunks;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_k          <= n_k;
        r_addr       <= n_addr;
        r_row        <= n_row;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_ogrant     <= n_ogrant;
        r_ostatus    <= n_ostatus;
    end

    always_comb begin
        jj       = (r_state == bba_pkg::ST_SPLIT_RD) ? (r_j - 3'd1) : r_j;
        sz       = 14'(14'd16 << jj);
        unique case (r_state)
            bba_pkg::ST_SPLIT_RD, bba_pkg::ST_SPLIT_WR: loc_addr = r_addr + sz;
            bba_pkg::ST_MERGE_RD, bba_pkg::ST_MERGE_CHK: loc_addr = r_addr ^ sz;
            default: loc_addr = r_addr;
        endcase
        loc      = bba_pkg::free_loc(jj, loc_addr);
        need     = 17'(i_request_bytes) + 17'(bba_pkg::HEADER_BYTES);
        kreq     = 3'd7;
        for (int i = 7; i >= 0; i--) begin
            if (need <= (17'd16 << i)) kreq = 3'(i);
        end
        blk      = i_block_address - 14'(bba_pkg::HEADER_BYTES);
        pick_bit = bba_pkg::lowest_set(fm_rd);
        rel_row  = 5'(r_row - bba_pkg::row_base(r_j));
        new_addr = 14'({rel_row, pick_bit, 4'b0000} << r_j);
        code     = 4'(om_rd >> {r_addr[6:4], 2'b00});
        nib_mask = 32'hF << {r_addr[6:4], 2'b00};
    end

    always_comb begin
        n_state      = r_state;
        n_j          = r_j;
        n_k          = r_k;
        n_addr       = r_addr;
        n_row        = r_row;
        n_chunks     = r_chunks;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_ovalid     = r_ovalid && !i_ready;
        n_ogrant     = r_ogrant;
        n_ostatus    = r_ostatus;
        o_ready      = (r_state == bba_pkg::ST_IDLE);

        fm_req.wr_en   = 1'b0;
        fm_req.wr_row  = loc.row;
        fm_req.wr_data = fm_rd;
        fm_req.rd_row  = loc.row;
        om_req.wr_en   = 1'b0;
        om_req.wr_row  = r_addr[13:7];
        om_req.wr_data = om_rd;
        om_req.rd_row  = r_addr[13:7];

        unique case (r_state)
            bba_pkg::ST_IDLE: begin
                om_req.rd_row = blk[13:7];
                n_res_addr    = 14'd0;
                if (i_valid) begin
                    if (i_operation == bba_pkg::OP_ALLOC) begin
                        if (need > 17'd2048) begin
                            n_res_status = bba_pkg::STAT_TOO_LARGE;
                            n_state      = bba_pkg::ST_DONE;
                        end else begin
                            n_k     = kreq;
                            n_j     = kreq;
                            n_state = bba_pkg::ST_SEARCH;
                        end
                    end else begin
                        n_addr = blk;
                        if (blk[3:0] != 4'd0) begin
                            n_res_status = bba_pkg::STAT_DOUBLE_FREE;
                            n_state      = bba_pkg::ST_DONE;
                        end else begin
                            n_state = bba_pkg::ST_FREE_CHK;
                        end
                    end
                end
            end
            bba_pkg::ST_SEARCH: begin
                fm_req.rd_row = fm_found_row;
                n_row         = fm_found_row;
                if (fm_found) begin
                    n_state = bba_pkg::ST_PICK;
                end else if (r_j != 3'd7) begin
                    n_j = r_j + 3'd1;
                end else if (r_chunks < 4'(bba_pkg::POOL_LIMIT)) begin
                    n_addr   = {r_chunks[2:0], 11'd0};
                    n_chunks = r_chunks + 4'd1;
                    n_state  = (r_k != 3'd7) ? bba_pkg::ST_SPLIT_RD : bba_pkg::ST_BOM_RD;
                end else begin
                    n_res_status = bba_pkg::STAT_NO_MEM;
                    n_state      = bba_pkg::ST_DONE;
                end
            end
            bba_pkg::ST_PICK: begin
                fm_req.wr_en   = 1'b1;
                fm_req.wr_row  = r_row;
                fm_req.wr_data = fm_rd & ~(32'd1 << pick_bit);
                n_addr         = new_addr;
                n_state        = (r_j != r_k) ? bba_pkg::ST_SPLIT_RD : bba_pkg::ST_BOM_RD;
            end
            bba_pkg::ST_SPLIT_RD: begin
                n_j     = r_j - 3'd1;
                n_state = bba_pkg::ST_SPLIT_WR;
            end
            bba_pkg::ST_SPLIT_WR: begin
                fm_req.wr_en   = 1'b1;
                fm_req.wr_data = fm_rd | (32'd1 << loc.bitn);
                n_state        = (r_j != r_k) ? bba_pkg::ST_SPLIT_RD : bba_pkg::ST_BOM_RD;
            end
            bba_pkg::ST_BOM_RD: begin
                n_state = bba_pkg::ST_BOM_WR;
            end
            bba_pkg::ST_BOM_WR: begin
                om_req.wr_en   = 1'b1;
                om_req.wr_data = (om_rd & ~nib_mask)
                               | (32'({1'b0, r_k} + 4'd1) << {r_addr[6:4], 2'b00});
                n_res_addr     = r_addr + 14'(bba_pkg::HEADER_BYTES);
                n_res_status   = bba_pkg::STAT_OK;
                n_state        = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_FREE_CHK: begin
                if (code == 4'd0 || code > 4'd8) begin
                    n_res_status = bba_pkg::STAT_DOUBLE_FREE;
                    n_state      = bba_pkg::ST_DONE;
                end else begin
                    om_req.wr_en   = 1'b1;
                    om_req.wr_data = om_rd & ~nib_mask;
                    n_j            = 3'(code - 4'd1);
                    n_state        = (code != 4'd8) ? bba_pkg::ST_MERGE_RD
                                                    : bba_pkg::ST_SETFREE_RD;
                end
            end
            bba_pkg::ST_MERGE_RD: begin
                n_state = bba_pkg::ST_MERGE_CHK;
            end
            bba_pkg::ST_MERGE_CHK: begin
                if (fm_rd[loc.bitn]) begin
                    fm_req.wr_en   = 1'b1;
                    fm_req.wr_data = fm_rd & ~(32'd1 << loc.bitn);
                    n_addr         = r_addr & ~sz;
                    n_j            = r_j + 3'd1;
                    n_state        = (r_j != 3'd6) ? bba_pkg::ST_MERGE_RD
                                                   : bba_pkg::ST_SETFREE_RD;
                end else begin
                    n_state = bba_pkg::ST_SETFREE_RD;
                end
            end
            bba_pkg::ST_SETFREE_RD: begin
                n_state = bba_pkg::ST_SETFREE_WR;
            end
            bba_pkg::ST_SETFREE_WR: begin
                fm_req.wr_en   = 1'b1;
                fm_req.wr_data = fm_rd | (32'd1 << loc.bitn);
                n_res_status   = bba_pkg::STAT_OK;
                n_state        = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid  = 1'b1;
                    n_ogrant  = r_res_addr;
                    n_ostatus = r_res_status;
                    n_state   = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid           = r_ovalid;
    assign o_granted_address = r_ogrant;
    assign o_status          = r_ostatus;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != bba_pkg::STAT_OK) |-> (o_granted_address == 14'd0))
        else $error("error result carries a non-zero address");

    a_pool_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunks <= 4'(bba_pkg::POOL_LIMIT))
        else $error("more chunks granted than the pool holds");

    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_SEARCH || r_state == bba_pkg::ST_SPLIT_WR) |-> (r_j >= r_k))
        else $error("working order fell below the requested order");

    a_grant_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::ST_BOM_WR) |=> (r_res_addr[3:0] == 4'(bba_pkg::HEADER_BYTES)))
        else $error("granted block is not aligned to the minimum block size");

endmodule

/* design/bba_free_map.sv */
// Free map store: 65 rows of 32 bits with per-row valid and non-empty flags and a row search.
module bba_free_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_mem_req i_req,
    input  logic [2:0]        i_order,
    output logic [31:0]       o_rd_data,
    output logic              o_found,
    output logic [6:0]        o_found_row
);

    logic [31:0] r_mem [0:bba_pkg::FREE_ROWS-1];
    logic [bba_pkg::FREE_ROWS-1:0] r_valid;
    logic [bba_pkg::FREE_ROWS-1:0] r_nz;
    logic [31:0] r_rdata;
    logic        r_rdv;
    logic [6:0]  base;
    logic [31:0] seg;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
        r_rdata <= r_mem[i_req.rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_nz    <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_rdv <= r_valid[i_req.rd_row];
            if (i_req.wr_en) begin
                r_valid[i_req.wr_row] <= 1'b1;
                r_nz[i_req.wr_row]    <= |i_req.wr_data;
            end
        end
    end

    always_comb begin
        base        = bba_pkg::row_base(i_order);
        seg         = 32'(r_nz >> base) & bba_pkg::row_mask(i_order);
        o_found     = |seg;
        o_found_row = base + 7'(bba_pkg::lowest_set(seg));
        o_rd_data   = r_rdv ? r_rdata : 32'd0;
    end

endmodule

/* design/bba_order_map.sv */
// Block order store: 128 rows of eight 4-bit order codes with per-row valid flags.
module bba_order_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_mem_req i_req,
    output logic [31:0]       o_rd_data
);

    logic [31:0] r_mem [0:bba_pkg::ORDER_ROWS-1];
    logic [bba_pkg::ORDER_ROWS-1:0] r_valid;
    logic [31:0] r_rdata;
    logic        r_rdv;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row] <= i_req.wr_data;
        end
        r_rdata <= r_mem[i_req.rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_rdv <= r_valid[i_req.rd_row];
            if (i_req.wr_en) begin
                r_valid[i_req.wr_row] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rdv ? r_rdata : 32'd0;

endmodule
